@@ design/ilt_pkg.sv @@
`timescale 1ns / 1ps
// ilt_pkg: types, constants, helpers and the microcode table of the
// iterative linear triangulation block. Depends on nothing.
package ilt_pkg;

   localparam int MAX_ITERATIONS = 10;
   localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);
   localparam int OUT_ITER_W = 4;
   localparam int OUT_ITER_MAX = 15;

   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;
   localparam int ACC_W = 50;
   localparam int PROD_W = 2 * DATA_W;
   localparam int QUO_W = DATA_W + FRAC_W;
   localparam int DIV_CNT_W = $clog2(QUO_W);

   localparam int THR_W = 17;
   localparam logic [THR_W-1:0] THR_RESET = 17'd7;

   localparam logic OPER_LOAD = 1'b0;
   localparam logic OPER_POINT = 1'b1;
   localparam int MAT_ROWS = 3;

   // register file layout
   localparam int CAM_ENTRIES = 24;
   localparam int CAM_STRIDE = 12;
   localparam int CLR_W = $clog2(CAM_ENTRIES);
   localparam int RF_CAM = 0;
   localparam int RF_RAW = 24;
   localparam int RF_A = 40;
   localparam int RF_M = 56;
   localparam int RF_RHS = 65;
   localparam int RF_X = 68;
   localparam int RF_W0 = 71;
   localparam int RF_W1 = 72;
   localparam int RF_N0 = 73;
   localparam int RF_N1 = 74;
   localparam int RF_TMP = 75;
   localparam int RF_FAC = 76;
   localparam int RF_DEPTH = 77;
   localparam int RF_ADDR_W = $clog2(RF_DEPTH);

   localparam int UCODE_DEPTH = 512;
   localparam int PC_W = $clog2(UCODE_DEPTH);
   localparam int FIN_PC = 0;
   localparam int PROG_START = 4;

   typedef logic [RF_ADDR_W-1:0] rf_addr_type;
   typedef logic [PC_W-1:0] pc_type;

   typedef enum logic [4:0] {
      OP_CLR,   // acc = 0
      OP_LDI,   // acc = 1.0
      OP_LDA,   // acc = rf[a]
      OP_ADD,   // acc += rf[a]
      OP_SUB,   // acc -= rf[a]
      OP_MAC,   // acc += rf[a] * rf[b]
      OP_MSC,   // acc -= rf[a] * rf[b]
      OP_MACC,  // acc += coord[a] * rf[b]
      OP_DIV,   // acc = rf[a] / rf[b]
      OP_ST,    // rf[a] = sat(acc)
      OP_PIVZ,  // rf[a] == 0: degenerate, finish
      OP_CHK,   // flag = |acc| <= threshold
      OP_CHKJ,  // flag and |acc| <= threshold: finish
      OP_JIT,   // pass limit reached: finish
      OP_STEP,  // count one pass
      OP_JMP,   // pc = target
      OP_OUT,   // result[b] = rf[a]
      OP_DONE   // hand the result over
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_EXEC,
      ST_MULACC,
      ST_DIVWAIT
   } state_type;

   typedef struct packed {
      op_type      op;
      rf_addr_type a;
      rf_addr_type b;
      pc_type      target;
   } ucode_word_type;

   typedef ucode_word_type [UCODE_DEPTH-1:0] ucode_rom_type;

   function automatic logic signed [DATA_W-1:0] sat_data(logic signed [ACC_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v[ACC_W-1:DATA_W-1] == {(ACC_W-DATA_W+1){v[ACC_W-1]}}) begin
         r = v[DATA_W-1:0];
      end else if (v[ACC_W-1]) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic ucode_word_type mk(op_type op, int a, int b, int t);
      ucode_word_type w;
      w.op = op;
      w.a = RF_ADDR_W'(a);
      w.b = RF_ADDR_W'(b);
      w.target = PC_W'(t);
      return w;
   endfunction

   function automatic ucode_rom_type build_ucode();
      ucode_rom_type rom;
      int pc;
      int row;
      int base;
      int solve_pc;
      for (int n = 0; n < UCODE_DEPTH; n++) rom[n] = mk(OP_DONE, 0, 0, 0);
      // finish sequence
      rom[0] = mk(OP_OUT, RF_X, 0, 0);
      rom[1] = mk(OP_OUT, RF_X + 1, 1, 0);
      rom[2] = mk(OP_OUT, RF_X + 2, 2, 0);
      rom[3] = mk(OP_DONE, 0, 0, 0);
      pc = PROG_START;
      rom[pc] = mk(OP_LDI, 0, 0, 0); pc++;
      rom[pc] = mk(OP_ST, RF_W0, 0, 0); pc++;
      rom[pc] = mk(OP_ST, RF_W1, 0, 0); pc++;
      // rows of the linear system
      for (int v = 0; v < 2; v++) begin
         for (int r = 0; r < 2; r++) begin
            row = v * 2 + r;
            base = RF_CAM + v * CAM_STRIDE;
            for (int j = 0; j < 4; j++) begin
               rom[pc] = mk(OP_CLR, 0, 0, 0); pc++;
               rom[pc] = mk(OP_MACC, row, base + 8 + j, 0); pc++;
               rom[pc] = mk(OP_SUB, base + r * 4 + j, 0, 0); pc++;
               if (j < 3) begin
                  rom[pc] = mk(OP_ST, RF_RAW + row * 4 + j, 0, 0); pc++;
               end else begin
                  rom[pc] = mk(OP_ST, RF_TMP, 0, 0); pc++;
                  rom[pc] = mk(OP_CLR, 0, 0, 0); pc++;
                  rom[pc] = mk(OP_SUB, RF_TMP, 0, 0); pc++;
                  rom[pc] = mk(OP_ST, RF_RAW + row * 4 + j, 0, 0); pc++;
               end
            end
         end
      end
      solve_pc = pc;
      // weighting
      for (int r = 0; r < 4; r++) begin
         for (int j = 0; j < 4; j++) begin
            rom[pc] = mk(OP_DIV, RF_RAW + r * 4 + j, (r < 2) ? RF_W0 : RF_W1, 0); pc++;
            rom[pc] = mk(OP_ST, RF_A + r * 4 + j, 0, 0); pc++;
         end
      end
      // normal equations
      for (int j = 0; j < 3; j++) begin
         for (int l = 0; l < 4; l++) begin
            rom[pc] = mk(OP_CLR, 0, 0, 0); pc++;
            for (int r = 0; r < 4; r++) begin
               rom[pc] = mk(OP_MAC, RF_A + r * 4 + j, RF_A + r * 4 + l, 0); pc++;
            end
            rom[pc] = mk(OP_ST, (l < 3) ? RF_M + j * 3 + l : RF_RHS + j, 0, 0); pc++;
         end
      end
      // forward elimination
      for (int k = 0; k < 3; k++) begin
         rom[pc] = mk(OP_PIVZ, RF_M + k * 3 + k, 0, 0); pc++;
         for (int i = k + 1; i < 3; i++) begin
            rom[pc] = mk(OP_DIV, RF_M + i * 3 + k, RF_M + k * 3 + k, 0); pc++;
            rom[pc] = mk(OP_ST, RF_FAC, 0, 0); pc++;
            for (int j = k; j < 3; j++) begin
               rom[pc] = mk(OP_LDA, RF_M + i * 3 + j, 0, 0); pc++;
               rom[pc] = mk(OP_MSC, RF_FAC, RF_M + k * 3 + j, 0); pc++;
               rom[pc] = mk(OP_ST, RF_M + i * 3 + j, 0, 0); pc++;
            end
            rom[pc] = mk(OP_LDA, RF_RHS + i, 0, 0); pc++;
            rom[pc] = mk(OP_MSC, RF_FAC, RF_RHS + k, 0); pc++;
            rom[pc] = mk(OP_ST, RF_RHS + i, 0, 0); pc++;
         end
      end
      // back substitution
      for (int k = 2; k >= 0; k--) begin
         rom[pc] = mk(OP_LDA, RF_RHS + k, 0, 0); pc++;
         for (int j = k + 1; j < 3; j++) begin
            rom[pc] = mk(OP_MSC, RF_M + k * 3 + j, RF_X + j, 0); pc++;
         end
         rom[pc] = mk(OP_ST, RF_TMP, 0, 0); pc++;
         rom[pc] = mk(OP_DIV, RF_TMP, RF_M + k * 3 + k, 0); pc++;
         rom[pc] = mk(OP_ST, RF_X + k, 0, 0); pc++;
      end
      // reweighting pass
      rom[pc] = mk(OP_JIT, 0, 0, 0); pc++;
      for (int v = 0; v < 2; v++) begin
         base = RF_CAM + v * CAM_STRIDE;
         rom[pc] = mk(OP_CLR, 0, 0, 0); pc++;
         rom[pc] = mk(OP_MAC, base + 8, RF_X, 0); pc++;
         rom[pc] = mk(OP_MAC, base + 9, RF_X + 1, 0); pc++;
         rom[pc] = mk(OP_MAC, base + 10, RF_X + 2, 0); pc++;
         rom[pc] = mk(OP_ADD, base + 11, 0, 0); pc++;
         rom[pc] = mk(OP_ST, RF_N0 + v, 0, 0); pc++;
      end
      rom[pc] = mk(OP_LDA, RF_W0, 0, 0); pc++;
      rom[pc] = mk(OP_SUB, RF_N0, 0, 0); pc++;
      rom[pc] = mk(OP_CHK, 0, 0, 0); pc++;
      rom[pc] = mk(OP_LDA, RF_W1, 0, 0); pc++;
      rom[pc] = mk(OP_SUB, RF_N1, 0, 0); pc++;
      rom[pc] = mk(OP_CHKJ, 0, 0, 0); pc++;
      rom[pc] = mk(OP_PIVZ, RF_N0, 0, 0); pc++;
      rom[pc] = mk(OP_PIVZ, RF_N1, 0, 0); pc++;
      rom[pc] = mk(OP_LDA, RF_N0, 0, 0); pc++;
      rom[pc] = mk(OP_ST, RF_W0, 0, 0); pc++;
      rom[pc] = mk(OP_LDA, RF_N1, 0, 0); pc++;
      rom[pc] = mk(OP_ST, RF_W1, 0, 0); pc++;
      rom[pc] = mk(OP_STEP, 0, 0, 0); pc++;
      rom[pc] = mk(OP_JMP, 0, 0, solve_pc); pc++;
      return rom;
   endfunction

   localparam ucode_rom_type UCODE = build_ucode();

endpackage

@@ design/ilt_if.sv @@
`timescale 1ns / 1ps
// ilt_req_if and ilt_rsp_if: valid/ready channels of the triangulation block.
// Depends on ilt_pkg for data widths.
interface ilt_req_if;
   logic valid;
   logic ready;
   logic operation;
   logic camera_select;
   logic [1:0] matrix_row;
   logic [1:0] matrix_col;
   logic signed [ilt_pkg::DATA_W-1:0] matrix_value;
   logic signed [ilt_pkg::DATA_W-1:0] first_x;
   logic signed [ilt_pkg::DATA_W-1:0] first_y;
   logic signed [ilt_pkg::DATA_W-1:0] second_x;
   logic signed [ilt_pkg::DATA_W-1:0] second_y;
   modport source (output valid, operation, camera_select, matrix_row, matrix_col,
                   matrix_value, first_x, first_y, second_x, second_y, input ready);
   modport sink (input valid, operation, camera_select, matrix_row, matrix_col,
                 matrix_value, first_x, first_y, second_x, second_y, output ready);
endinterface

interface ilt_rsp_if;
   logic valid;
   logic ready;
   logic signed [ilt_pkg::DATA_W-1:0] point_x;
   logic signed [ilt_pkg::DATA_W-1:0] point_y;
   logic signed [ilt_pkg::DATA_W-1:0] point_z;
   logic [ilt_pkg::OUT_ITER_W-1:0] iterations_used;
   logic degenerate;
   modport source (output valid, point_x, point_y, point_z, iterations_used, degenerate,
                   input ready);
   modport sink (input valid, point_x, point_y, point_z, iterations_used, degenerate,
                 output ready);
endinterface

@@ design/ilt_ram.sv @@
`timescale 1ns / 1ps
// ilt_ram: generic RAM, one write port, two registered read ports.
// Depends on nothing.
module ilt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end
endmodule

@@ design/ilt_div.sv @@
`timescale 1ns / 1ps
// ilt_div: iterative Q16.16 divider, one quotient bit per cycle, truncating.
// Depends on ilt_pkg.
module ilt_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [ilt_pkg::DATA_W-1:0]  numer,
   input  logic signed [ilt_pkg::DATA_W-1:0]  denom,
   output logic                               done,
   output logic signed [ilt_pkg::QUO_W:0]     quotient
);
   localparam int DW = ilt_pkg::DATA_W;
   localparam int QW = ilt_pkg::QUO_W;
   localparam int CW = ilt_pkg::DIV_CNT_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [DW-1:0] den_ff, den_in;
   logic          neg_ff, neg_in;
   logic [DW:0]   rem_sh;
   logic [DW:0]   rem_diff;
   logic          fits;
   logic [DW-1:0] mag_n, mag_d;

   assign mag_n = numer[DW-1] ? DW'(-numer) : DW'(numer);
   assign mag_d = denom[DW-1] ? DW'(-denom) : DW'(denom);
   assign rem_sh = {rem_ff, quo_ff[QW-1]};
   assign rem_diff = rem_sh - {1'b0, den_ff};
   assign fits = rem_sh >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = {mag_n, {ilt_pkg::FRAC_W{1'b0}}};
         den_in = mag_d;
         neg_in = numer[DW-1] ^ denom[DW-1];
      end else if (busy_ff) begin
         rem_in = fits ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
         quo_in = {quo_ff[QW-2:0], fits};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
endmodule

@@ design/iterative_linear_triangulation.sv @@
`timescale 1ns / 1ps
// iterative_linear_triangulation: two-view point triangulation by reweighted
// least squares, run by a microcoded sequencer. Depends on ilt_pkg, ilt_if,
// ilt_ram and ilt_div.
//
// Usage: req_ch carries one transaction per item. A load transaction
// (operation 0) writes one entry of a 3x4 camera matrix and gives no result;
// a load with row three is dropped. A point transaction (operation 1) gives
// one result on rsp_ch: the point, the number of reweighting passes and a
// degenerate flag. csr_write_enable/csr_write_data set the Q16.16
// convergence threshold; write it only while the block is idle.
// A point runs one solve and then up to ten reweighting passes, each with a
// new solve. The run time is set mostly by the shared divider, 48 quotient
// bits per division (22 divisions per solve), and by the fetch and execute
// of each microcode step. Points are worked one at a time.
// After reset the 24 camera entries are cleared with req_ch.ready low.
// The result sits in an output register: a new transaction is taken while
// it waits, and the sequencer stalls only on its final step if the receiver
// has not yet taken the previous result.
module iterative_linear_triangulation (
   input  logic                            clock,
   input  logic                            reset,
   ilt_req_if.sink                         req_ch,
   ilt_rsp_if.source                       rsp_ch,
   input  logic                            csr_write_enable,
   input  logic [ilt_pkg::THR_W-1:0]       csr_write_data
);
   localparam int DW = ilt_pkg::DATA_W;
   localparam int AW = ilt_pkg::RF_ADDR_W;
   localparam int ACW = ilt_pkg::ACC_W;
   localparam int PW = ilt_pkg::PC_W;
   localparam int IW = ilt_pkg::ITER_W;
   localparam int CLW = ilt_pkg::CLR_W;

   ilt_pkg::state_type      state_ff, state_in;
   ilt_pkg::ucode_word_type uw;
   ilt_pkg::ucode_word_type uw_ff;
   logic [PW-1:0]           pc_ff, pc_in;
   logic signed [ACW-1:0]   acc_ff, acc_in;
   logic signed [ilt_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [DW-1:0]    coord_ff [4];
   logic signed [DW-1:0]    coord_in [4];
   logic signed [DW-1:0]    res_ff [3];
   logic signed [DW-1:0]    res_in [3];
   logic [IW-1:0]           iters_ff, iters_in;
   logic                    deg_ff, deg_in;
   logic                    flag_ff, flag_in;
   logic [ilt_pkg::THR_W-1:0] thr_ff, thr_in;
   logic [CLW-1:0]          clr_ff, clr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0]    out_x_ff, out_x_in, out_y_ff, out_y_in, out_z_ff, out_z_in;
   logic [ilt_pkg::OUT_ITER_W-1:0] out_iter_ff, out_iter_in;
   logic                    out_deg_ff, out_deg_in;

   logic                    ram_we;
   logic [AW-1:0]           ram_waddr;
   logic [DW-1:0]           ram_wdata;
   logic [DW-1:0]           ram_rd_a, ram_rd_b;
   logic signed [DW-1:0]    rd_a, rd_b;
   logic signed [DW-1:0]    mul_a;
   logic signed [ACW-1:0]   rd_a_ext, prod_q, thr_ext;
   logic                    within_thr;
   logic                    done_go;
   logic [AW-1:0]           load_addr;
   logic                    div_start, div_done;
   logic signed [ilt_pkg::QUO_W:0] div_quo;

   // microcode rom read with a registered word that tracks pc_ff
   assign uw = uw_ff;
   assign rd_a = $signed(ram_rd_a);
   assign rd_b = $signed(ram_rd_b);
   assign rd_a_ext = ACW'(rd_a);
   assign mul_a = (uw.op == ilt_pkg::OP_MACC) ? coord_ff[uw.a[1:0]] : rd_a;
   assign prod_q = ACW'(prod_ff >>> ilt_pkg::FRAC_W);
   assign thr_ext = ACW'(thr_ff);
   assign within_thr = (acc_ff <= thr_ext) && (acc_ff >= -thr_ext);
   assign done_go = !rsp_valid_ff || rsp_ch.ready;
   // camera*12 + row*4 + col
   assign load_addr = AW'(req_ch.camera_select ? ilt_pkg::CAM_STRIDE : 0)
                      + AW'({req_ch.matrix_row, req_ch.matrix_col});

   ilt_ram #(.WIDTH(DW), .DEPTH(ilt_pkg::RF_DEPTH)) u_rf (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_addr_a (uw.a),
      .rd_addr_b (uw.b),
      .rd_data_a (ram_rd_a),
      .rd_data_b (ram_rd_b)
   );

   ilt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (rd_a),
      .denom    (rd_b),
      .done     (div_done),
      .quotient (div_quo)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ilt_pkg::ST_CLEAR: begin
            if (clr_ff == CLW'(ilt_pkg::CAM_ENTRIES - 1)) state_in = ilt_pkg::ST_IDLE;
         end
         ilt_pkg::ST_IDLE: begin
            if (req_ch.valid && req_ch.operation == ilt_pkg::OPER_POINT) begin
               state_in = ilt_pkg::ST_FETCH;
            end
         end
         ilt_pkg::ST_FETCH: state_in = ilt_pkg::ST_EXEC;
         ilt_pkg::ST_EXEC: begin
            case (uw.op)
               ilt_pkg::OP_MAC, ilt_pkg::OP_MSC, ilt_pkg::OP_MACC: begin
                  state_in = ilt_pkg::ST_MULACC;
               end
               ilt_pkg::OP_DIV: state_in = ilt_pkg::ST_DIVWAIT;
               ilt_pkg::OP_DONE: begin
                  state_in = done_go ? ilt_pkg::ST_IDLE : ilt_pkg::ST_EXEC;
               end
               default: state_in = ilt_pkg::ST_FETCH;
            endcase
         end
         ilt_pkg::ST_MULACC: state_in = ilt_pkg::ST_FETCH;
         ilt_pkg::ST_DIVWAIT: begin
            if (div_done) state_in = ilt_pkg::ST_FETCH;
         end
         default: state_in = ilt_pkg::ST_IDLE;
      endcase
   end

   // datapath and control
   always_comb begin
      pc_in = pc_ff;
      acc_in = acc_ff;
      prod_in = prod_ff;
      coord_in = coord_ff;
      res_in = res_ff;
      iters_in = iters_ff;
      deg_in = deg_ff;
      flag_in = flag_ff;
      clr_in = clr_ff;
      thr_in = csr_write_enable ? csr_write_data : thr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      out_x_in = out_x_ff;
      out_y_in = out_y_ff;
      out_z_in = out_z_ff;
      out_iter_in = out_iter_ff;
      out_deg_in = out_deg_ff;
      ram_we = 1'b0;
      ram_waddr = uw.a;
      ram_wdata = ilt_pkg::sat_data(acc_ff);
      div_start = 1'b0;
      req_ch.ready = 1'b0;
      case (state_ff)
         ilt_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
            ram_waddr = AW'(clr_ff);
            ram_wdata = '0;
            clr_in = clr_ff + CLW'(1);
         end
         ilt_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               if (req_ch.operation == ilt_pkg::OPER_LOAD) begin
                  if (req_ch.matrix_row < 2'(ilt_pkg::MAT_ROWS)) begin
                     ram_we = 1'b1;
                     ram_waddr = load_addr;
                     ram_wdata = req_ch.matrix_value;
                  end
               end else begin
                  coord_in[0] = req_ch.first_x;
                  coord_in[1] = req_ch.first_y;
                  coord_in[2] = req_ch.second_x;
                  coord_in[3] = req_ch.second_y;
                  pc_in = PW'(ilt_pkg::PROG_START);
                  iters_in = '0;
                  deg_in = 1'b0;
               end
            end
         end
         ilt_pkg::ST_EXEC: begin
            pc_in = pc_ff + PW'(1);
            case (uw.op)
               ilt_pkg::OP_CLR: acc_in = '0;
               ilt_pkg::OP_LDI: acc_in = ACW'(1) <<< ilt_pkg::FRAC_W;
               ilt_pkg::OP_LDA: acc_in = rd_a_ext;
               ilt_pkg::OP_ADD: acc_in = acc_ff + rd_a_ext;
               ilt_pkg::OP_SUB: acc_in = acc_ff - rd_a_ext;
               ilt_pkg::OP_MAC, ilt_pkg::OP_MSC, ilt_pkg::OP_MACC: begin
                  pc_in = pc_ff;
                  prod_in = mul_a * rd_b;
               end
               ilt_pkg::OP_DIV: begin
                  pc_in = pc_ff;
                  div_start = 1'b1;
               end
               ilt_pkg::OP_ST: ram_we = 1'b1;
               ilt_pkg::OP_PIVZ: begin
                  if (rd_a == '0) begin
                     deg_in = 1'b1;
                     pc_in = PW'(ilt_pkg::FIN_PC);
                  end
               end
               ilt_pkg::OP_CHK: flag_in = within_thr;
               ilt_pkg::OP_CHKJ: begin
                  if (flag_ff && within_thr) pc_in = PW'(ilt_pkg::FIN_PC);
               end
               ilt_pkg::OP_JIT: begin
                  if (iters_ff == IW'(ilt_pkg::MAX_ITERATIONS)) pc_in = PW'(ilt_pkg::FIN_PC);
               end
               ilt_pkg::OP_STEP: iters_in = iters_ff + IW'(1);
               ilt_pkg::OP_JMP: pc_in = uw.target;
               ilt_pkg::OP_OUT: res_in[uw.b[1:0]] = deg_ff ? '0 : rd_a;
               ilt_pkg::OP_DONE: begin
                  pc_in = pc_ff;
                  if (done_go) begin
                     rsp_valid_in = 1'b1;
                     out_x_in = res_ff[0];
                     out_y_in = res_ff[1];
                     out_z_in = res_ff[2];
                     out_iter_in = (32'(iters_ff) > ilt_pkg::OUT_ITER_MAX)
                                   ? ilt_pkg::OUT_ITER_W'(ilt_pkg::OUT_ITER_MAX)
                                   : ilt_pkg::OUT_ITER_W'(iters_ff);
                     out_deg_in = deg_ff;
                  end
               end
               default: pc_in = pc_ff;
            endcase
         end
         ilt_pkg::ST_MULACC: begin
            pc_in = pc_ff + PW'(1);
            if (uw.op == ilt_pkg::OP_MSC) acc_in = acc_ff - prod_q;
            else acc_in = acc_ff + prod_q;
         end
         ilt_pkg::ST_DIVWAIT: begin
            if (div_done) begin
               pc_in = pc_ff + PW'(1);
               acc_in = ACW'(div_quo);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ilt_pkg::ST_CLEAR;
         clr_ff <= '0;
         thr_ff <= ilt_pkg::THR_RESET;
         rsp_valid_ff <= 1'b0;
         pc_ff <= '0;
         uw_ff <= ilt_pkg::UCODE[ilt_pkg::FIN_PC];
         iters_ff <= '0;
         deg_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         thr_ff <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
         pc_ff <= pc_in;
         uw_ff <= ilt_pkg::UCODE[pc_in];
         iters_ff <= iters_in;
         deg_ff <= deg_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      prod_ff <= prod_in;
      coord_ff <= coord_in;
      res_ff <= res_in;
      flag_ff <= flag_in;
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      out_z_ff <= out_z_in;
      out_iter_ff <= out_iter_in;
      out_deg_ff <= out_deg_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.point_x = out_x_ff;
   assign rsp_ch.point_y = out_y_ff;
   assign rsp_ch.point_z = out_z_ff;
   assign rsp_ch.iterations_used = out_iter_ff;
   assign rsp_ch.degenerate = out_deg_ff;

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.degenerate |->
         rsp_ch.point_x == '0 && rsp_ch.point_y == '0 && rsp_ch.point_z == '0)
      else $error("degenerate result with nonzero point");

   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> 32'(rsp_ch.iterations_used) <= ilt_pkg::MAX_ITERATIONS)
      else $error("pass count beyond limit");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ilt_pkg::ST_CLEAR |-> !req_ch.ready)
      else $error("transaction taken during camera clear");

   a_div_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ilt_pkg::ST_DIVWAIT && !div_done |=> state_ff == ilt_pkg::ST_DIVWAIT)
      else $error("sequencer left divide wait early");
endmodule

@@ test/ilt_checker.sv @@
`timescale 1ns / 1ps
// ilt_checker: watches the request, result and csr ports of the triangulation
// block, predicts every result and compares it. Depends on ilt_pkg and ilt_if.
module ilt_checker (
   input  logic                      clock,
   input  logic                      reset,
   ilt_req_if                        req_ch,
   ilt_rsp_if                        rsp_ch,
   input  logic                      csr_write_enable,
   input  logic [ilt_pkg::THR_W-1:0] csr_write_data,
   output int                        failures,
   output int                        outstanding
);
   localparam int FIFO_DEPTH = 1024;

   typedef struct {
      logic signed [ilt_pkg::DATA_W-1:0] px;
      logic signed [ilt_pkg::DATA_W-1:0] py;
      logic signed [ilt_pkg::DATA_W-1:0] pz;
      logic [ilt_pkg::OUT_ITER_W-1:0]    iters;
      logic                              degen;
   } point_result_type;

   point_result_type expected_points [FIFO_DEPTH];
   int wr_count = 0;
   int rd_count = 0;
   longint cameras[ilt_pkg::CAM_ENTRIES];
   longint threshold;

   assign outstanding = wr_count - rd_count;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint fx_mul(longint a, longint b);
      return (a * b) >>> ilt_pkg::FRAC_W;
   endfunction

   function automatic longint fx_div(longint n, longint d);
      return clamp32((n * 65536) / d);
   endfunction

   // weighted normal equations, elimination without pivoting, back substitution
   function automatic bit solve_points(input longint rows[4][4], input longint w0,
                                       input longint w1, inout longint x[3]);
      longint a[4][4];
      longint m[3][3];
      longint rhs[3];
      longint s;
      longint f;
      for (int r = 0; r < 4; r++)
         for (int j = 0; j < 4; j++) a[r][j] = fx_div(rows[r][j], r < 2 ? w0 : w1);
      for (int j = 0; j < 3; j++) begin
         for (int l = 0; l < 3; l++) begin
            s = 0;
            for (int r = 0; r < 4; r++) s += fx_mul(a[r][j], a[r][l]);
            m[j][l] = clamp32(s);
         end
         s = 0;
         for (int r = 0; r < 4; r++) s += fx_mul(a[r][j], a[r][3]);
         rhs[j] = clamp32(s);
      end
      for (int k = 0; k < 3; k++) begin
         if (m[k][k] == 0) return 0;
         for (int i = k + 1; i < 3; i++) begin
            f = fx_div(m[i][k], m[k][k]);
            for (int j = k; j < 3; j++) m[i][j] = clamp32(m[i][j] - fx_mul(f, m[k][j]));
            rhs[i] = clamp32(rhs[i] - fx_mul(f, rhs[k]));
         end
      end
      for (int k = 2; k >= 0; k--) begin
         s = rhs[k];
         for (int j = k + 1; j < 3; j++) s -= fx_mul(m[k][j], x[j]);
         x[k] = fx_div(clamp32(s), m[k][k]);
      end
      return 1;
   endfunction

   function automatic longint view_depth(int base, longint x[3]);
      return clamp32(fx_mul(cameras[base + 8], x[0]) + fx_mul(cameras[base + 9], x[1])
                     + fx_mul(cameras[base + 10], x[2]) + cameras[base + 11]);
   endfunction

   function automatic point_result_type triangulate(longint c0, longint c1, longint c2,
                                                    longint c3);
      point_result_type res;
      longint coord[4];
      longint rows[4][4];
      longint x[3];
      longint w0;
      longint w1;
      longint n0;
      longint n1;
      longint t;
      int iters;
      bit degen;
      coord = '{c0, c1, c2, c3};
      x = '{0, 0, 0};
      w0 = 65536;
      w1 = 65536;
      iters = 0;
      degen = 0;
      for (int v = 0; v < 2; v++)
         for (int r = 0; r < 2; r++)
            for (int j = 0; j < 4; j++) begin
               t = clamp32(fx_mul(coord[v*2+r], cameras[v*ilt_pkg::CAM_STRIDE+8+j])
                           - cameras[v*ilt_pkg::CAM_STRIDE+r*4+j]);
               rows[v*2+r][j] = (j < 3) ? t : clamp32(-t);
            end
      if (!solve_points(rows, w0, w1, x)) begin
         degen = 1;
      end else begin
         for (int pass = 0; pass < ilt_pkg::MAX_ITERATIONS; pass++) begin
            n0 = view_depth(0, x);
            n1 = view_depth(ilt_pkg::CAM_STRIDE, x);
            if ((w0 - n0 <= threshold && n0 - w0 <= threshold)
                && (w1 - n1 <= threshold && n1 - w1 <= threshold)) break;
            if (n0 == 0 || n1 == 0) begin
               degen = 1;
               break;
            end
            w0 = n0;
            w1 = n1;
            iters++;
            if (!solve_points(rows, w0, w1, x)) begin
               degen = 1;
               break;
            end
         end
      end
      if (degen) x = '{0, 0, 0};
      res.px = x[0][31:0];
      res.py = x[1][31:0];
      res.pz = x[2][31:0];
      res.iters = ilt_pkg::OUT_ITER_W'((iters > ilt_pkg::OUT_ITER_MAX)
                                       ? ilt_pkg::OUT_ITER_MAX : iters);
      res.degen = degen;
      return res;
   endfunction

   always @(posedge clock) begin
      point_result_type exp_r;
      int idx;
      if (reset) begin
         foreach (cameras[i]) cameras[i] = 0;
         threshold = ilt_pkg::THR_RESET;
         wr_count = 0;
         rd_count = 0;
         failures = 0;
      end else begin
         if (csr_write_enable) threshold = csr_write_data;
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.operation == ilt_pkg::OPER_LOAD) begin
               if (req_ch.matrix_row < ilt_pkg::MAT_ROWS) begin
                  idx = int'(req_ch.camera_select) * ilt_pkg::CAM_STRIDE
                        + int'(req_ch.matrix_row) * 4 + int'(req_ch.matrix_col);
                  cameras[idx] = req_ch.matrix_value;
               end
            end else begin
               expected_points[wr_count % FIFO_DEPTH] =
                  triangulate(req_ch.first_x, req_ch.first_y,
                              req_ch.second_x, req_ch.second_y);
               wr_count++;
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (wr_count == rd_count) begin
               $error("result transaction with no point pending");
               failures++;
            end else begin
               exp_r = expected_points[rd_count % FIFO_DEPTH];
               rd_count++;
               if (rsp_ch.point_x !== exp_r.px) begin
                  $error("point_x expected %0d got %0d", exp_r.px, rsp_ch.point_x);
                  failures++;
               end
               if (rsp_ch.point_y !== exp_r.py) begin
                  $error("point_y expected %0d got %0d", exp_r.py, rsp_ch.point_y);
                  failures++;
               end
               if (rsp_ch.point_z !== exp_r.pz) begin
                  $error("point_z expected %0d got %0d", exp_r.pz, rsp_ch.point_z);
                  failures++;
               end
               if (rsp_ch.iterations_used !== exp_r.iters) begin
                  $error("iterations_used expected %0d got %0d", exp_r.iters,
                         rsp_ch.iterations_used);
                  failures++;
               end
               if (rsp_ch.degenerate !== exp_r.degen) begin
                  $error("degenerate expected %0d got %0d", exp_r.degen,
                         rsp_ch.degenerate);
                  failures++;
               end
            end
         end
      end
   end
endmodule

@@ test/iterative_linear_triangulation_tb.sv @@
`timescale 1ns / 1ps
// iterative_linear_triangulation_tb: drives camera loads and point transactions
// with random gaps and stalls and gives the verdict. Depends on ilt_pkg, ilt_if,
// the block and ilt_checker.
module iterative_linear_triangulation_tb;
   localparam longint ONE = 65536;
   localparam int CYCLE_LIMIT = 30000000;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [ilt_pkg::THR_W-1:0] csr_write_data = '0;
   int failures;
   int outstanding;
   int cycles = 0;
   int burst_left = 0;
   int sent = 0;
   bit hold_off = 0;

   ilt_req_if req_ch();
   ilt_rsp_if rsp_ch();

   iterative_linear_triangulation dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data));

   ilt_checker u_checker (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .failures(failures), .outstanding(outstanding));

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver: one of four random stall patterns, each held for a random run
   initial begin
      int mode;
      rsp_ch.ready = 0;
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(50, 400)) begin
            @(posedge clock);
            if (hold_off) rsp_ch.ready <= 0;
            else if (mode == 0) rsp_ch.ready <= 1;
            else if (mode == 1) rsp_ch.ready <= 1'($urandom_range(0, 1));
            else if (mode == 2) rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            else rsp_ch.ready <= ($urandom_range(0, 9) != 0);
         end
      end
   end

   // long receiver hold-off midway through the run, counted here
   initial begin
      wait (sent > 250);
      @(posedge clock);
      hold_off = 1;
      repeat (60000) @(posedge clock);
      hold_off = 0;
   end

   task automatic send(logic oper, logic cam, logic [1:0] row, logic [1:0] col,
                       logic [31:0] value, logic [31:0] fx, logic [31:0] fy,
                       logic [31:0] sx, logic [31:0] sy);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 10);
         gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid <= 0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1;
      req_ch.operation <= oper;
      req_ch.camera_select <= cam;
      req_ch.matrix_row <= row;
      req_ch.matrix_col <= col;
      req_ch.matrix_value <= value;
      req_ch.first_x <= fx;
      req_ch.first_y <= fy;
      req_ch.second_x <= sx;
      req_ch.second_y <= sy;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
   endtask

   task automatic load(int cam, int row, int col, longint value);
      send(ilt_pkg::OPER_LOAD, cam[0], row[1:0], col[1:0], value[31:0], $urandom,
           $urandom, $urandom, $urandom);
   endtask

   task automatic point(longint fx, longint fy, longint sx, longint sy);
      send(ilt_pkg::OPER_POINT, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
           2'($urandom_range(0, 3)), $urandom, fx[31:0], fy[31:0], sx[31:0], sy[31:0]);
   endtask

   // drain all results, let the block settle, then set the threshold
   task automatic set_threshold(logic [ilt_pkg::THR_W-1:0] value);
      req_ch.valid <= 0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_write_enable <= 1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   // a plausible camera: near-identity rotation, modest translation, positive depth
   task automatic load_camera(int cam);
      longint value;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 4; c++) begin
            if (c == 3) value = (r == 2) ? $urandom_range(ONE, 4*ONE)
                                         : longint'($urandom_range(0, 2*ONE)) - ONE;
            else value = (r == c ? ONE : 0) + longint'($urandom_range(0, ONE/2)) - ONE/4;
            load(cam, r, c, value);
         end
   endtask

   initial begin
      longint v;
      req_ch.valid = 0;
      req_ch.operation = ilt_pkg::OPER_LOAD;
      req_ch.camera_select = 0;
      req_ch.matrix_row = 0;
      req_ch.matrix_col = 0;
      req_ch.matrix_value = 0;
      req_ch.first_x = 0;
      req_ch.first_y = 0;
      req_ch.second_x = 0;
      req_ch.second_y = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // all-zero cameras: singular system
      point(ONE, -ONE, 0, ONE/2);
      // two views a unit baseline apart along x
      for (int cam = 0; cam < 2; cam++)
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 4; c++)
               load(cam, r, c, (r == c) ? ONE : (cam == 1 && r == 0 && c == 3) ? -ONE : 0);
      // row three load is dropped
      load(1, 3, 2, 32'h7fff_ffff);
      point(ONE/20, ONE/40, -ONE/5, ONE/40);
      point(ONE/8, -ONE/8, -ONE/4, -ONE/8);
      point(32'sh7fff_ffff, -32'sh8000_0000, -32'sh8000_0000, 32'sh7fff_ffff);
      point(0, 0, 0, 0);
      set_threshold(0);
      point(ONE/20, ONE/40, -ONE/5, ONE/40);
      set_threshold(65536);
      point(ONE/20, ONE/40, -ONE/5, ONE/40);
      load(0, 2, 3, -32'sh8000_0000);
      point(ONE/3, ONE/7, ONE/5, -ONE/9);
      set_threshold(ilt_pkg::THR_RESET);

      for (int phase = 0; phase < 4; phase++) begin
         for (int seq = 0; seq < 8; seq++) begin
            if ($urandom_range(0, 4) != 0) begin
               load_camera($urandom_range(0, 1));
               if ($urandom_range(0, 2) == 0) load_camera($urandom_range(0, 1));
               repeat ($urandom_range(1, 3))
                  point(longint'($urandom_range(0, 2*ONE)) - ONE,
                        longint'($urandom_range(0, 2*ONE)) - ONE,
                        longint'($urandom_range(0, 2*ONE)) - ONE,
                        longint'($urandom_range(0, 2*ONE)) - ONE);
            end else begin
               // noise: any entry, any value, full-range coordinates
               repeat ($urandom_range(1, 4)) begin
                  v = $signed($urandom);
                  load($urandom_range(0, 1), $urandom_range(0, 3), $urandom_range(0, 3), v);
               end
               point($signed($urandom), $signed($urandom), $signed($urandom),
                     $signed($urandom));
            end
         end
         case (phase)
            0: set_threshold(ilt_pkg::THR_W'($urandom_range(0, 65536)));
            1: set_threshold(17'h1ffff & 17'd65536);
            2: set_threshold(ilt_pkg::THR_W'($urandom_range(0, 40)));
            default: ;
         endcase
      end

      req_ch.valid <= 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
